/* rtl/core/palette_color_quantizer_defines.svh */
// Assertion helpers shared by the core; clk and arst_n must be in scope.
`ifndef PALETTE_COLOR_QUANTIZER_DEFINES_SVH
`define PALETTE_COLOR_QUANTIZER_DEFINES_SVH

// Same-cycle implication.
`define PCQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette_color_quantizer: assertion failed");

// Next-cycle implication.
`define PCQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette_color_quantizer: assertion failed");

`endif

/* rtl/core/pcq_pkg.sv */
`timescale 1ns / 1ps

package pcq_pkg;

	localparam int PALETTE_DEPTH_DEF = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int DIST_W     = 20;

	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = CFG_IDX_W'(1);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

endpackage

/* rtl/core/palette_color_quantizer.sv */
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// config    cfg_we                  cfg_index, cfg_data
// input     in_valid / in_ready     mode, red_in, green_in, blue_in, entry_index
// output    out_valid / out_ready   red_out, green_out, blue_out, chosen_index, from_palette
//
// Load beats are taken in idle and may follow back to back.
// Palette pixel: one entry read from the palette RAM per cycle.
// Uniform pixel: bit-serial step division, then bit-serial remainder per lane.
// Reset clears control, sets palette count to 0 and level count to 2; palette RAM holds garbage until loaded.
// A finished result waits in the output register; a new beat is taken meanwhile.

`include "palette_color_quantizer_defines.svh"

module palette_color_quantizer
	import pcq_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [4:0]            entry_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic [4:0]            chosen_index,
	output logic                  from_palette
);

	localparam int AW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNTW = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SNAP  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	state_t state_q, state_d;

	logic [5:0]        palette_count_q;
	logic [8:0]        level_count_q;
	logic [CNTW-1:0]   eff_cnt;
	logic [CNTW-1:0]   eff_cnt_q;
	logic              from_pal_q;
	rgb_t              px_q;
	rgb_t              in_px;

	logic              in_fire;
	logic              mem_we;
	logic [AW-1:0]     waddr;
	logic [23:0]       palette_mem_q [PALETTE_DEPTH];
	logic              rd_en;
	logic [AW-1:0]     addr_q;
	logic              scan_last;

	logic [23:0]       mem_rdata_s1;
	logic              valid_s1, last_s1, first_s1;
	logic [AW-1:0]     slot_s1;
	logic [7:0]        dr, dg, db;

	logic              valid_s2, last_s2, first_s2;
	logic [AW-1:0]     slot_s2;
	logic [23:0]       color_s2;
	logic [15:0]       sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] dist_s2;
	logic              take_s2;

	logic [DIST_W-1:0] best_dist_q;
	logic [AW-1:0]     best_slot_q;
	logic [23:0]       best_color_q;

	logic              snap_start;
	logic              snap_done;
	rgb_t              snap_res;

	logic              out_load;
	logic              out_valid_q;
	rgb_t              out_px_q;
	logic [4:0]        out_idx_q;
	logic              out_pal_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign in_px    = '{r: red_in, g: green_in, b: blue_in};

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_count_q <= '0;
			level_count_q   <= 9'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PALETTE_COUNT: palette_count_q <= cfg_data[5:0];
				REG_LEVEL_COUNT:   level_count_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if ({26'd0, palette_count_q} > 32'(PALETTE_DEPTH)) begin
			eff_cnt = CNTW'(PALETTE_DEPTH);
		end else begin
			eff_cnt = CNTW'(palette_count_q);
		end
	end

	// Palette RAM: writes only in idle, reads only while scanning, so no overlap.
	assign mem_we    = in_fire && mode && ({27'd0, entry_index} < 32'(PALETTE_DEPTH));
	assign waddr     = AW'(entry_index);
	assign rd_en     = (state_q == ST_SCAN);
	assign scan_last = (CNTW'(addr_q) + CNTW'(1)) == eff_cnt_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			palette_mem_q[waddr] <= {red_in, green_in, blue_in};
		end
		if (rd_en) begin
			mem_rdata_s1 <= palette_mem_q[addr_q];
		end
	end

	assign snap_start = in_fire && !mode && (eff_cnt == '0);

	pcq_snap u_snap (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (snap_start),
		.pixel       (in_px),
		.level_count (level_count_q),
		.done        (snap_done),
		.result      (snap_res)
	);

	// Stage 1 -> 2: per-channel squared difference
	assign dr = abs_diff(px_q.r, mem_rdata_s1[23:16]);
	assign dg = abs_diff(px_q.g, mem_rdata_s1[15:8]);
	assign db = abs_diff(px_q.b, mem_rdata_s1[7:0]);

	// Stage 2: weighted sum and running minimum; first entry always wins
	assign dist_s2 = (DIST_W'(sq_r_s2) << 1) + DIST_W'(sq_r_s2)
		+ (DIST_W'(sq_g_s2) << 2) + (DIST_W'(sq_b_s2) << 1);
	assign take_s2 = valid_s2 && (first_s2 || (dist_s2 < best_dist_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !mode) begin
					state_d = (eff_cnt == '0) ? ST_SNAP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_SNAP: begin
				if (snap_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			best_dist_q <= '1;
			best_slot_q <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
			if (take_s2) begin
				best_dist_q <= dist_s2;
				best_slot_q <= slot_s2;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !mode) begin
			px_q       <= in_px;
			eff_cnt_q  <= eff_cnt;
			from_pal_q <= (eff_cnt != '0);
		end
		if (in_fire) begin
			addr_q <= '0;
		end else if (rd_en) begin
			addr_q <= addr_q + AW'(1);
		end

		last_s1  <= scan_last;
		first_s1 <= (addr_q == '0);
		slot_s1  <= addr_q;

		sq_r_s2  <= 16'(dr) * 16'(dr);
		sq_g_s2  <= 16'(dg) * 16'(dg);
		sq_b_s2  <= 16'(db) * 16'(db);
		color_s2 <= mem_rdata_s1;
		slot_s2  <= slot_s1;
		last_s2  <= last_s1;
		first_s2 <= first_s1;

		if (take_s2) begin
			best_color_q <= color_s2;
		end

		if (out_load) begin
			if (from_pal_q) begin
				out_px_q  <= best_color_q;
				out_idx_q <= 5'(best_slot_q);
				out_pal_q <= 1'b1;
			end else begin
				out_px_q  <= snap_res;
				out_idx_q <= '0;
				out_pal_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign red_out      = out_px_q.r;
	assign green_out    = out_px_q.g;
	assign blue_out     = out_px_q.b;
	assign chosen_index = out_idx_q;
	assign from_palette = out_pal_q;

	`PCQ_ASSERT_IMPL(a_no_rd_wr_overlap, mem_we, !rd_en)
	`PCQ_ASSERT_IMPL(a_scan_in_range, rd_en, CNTW'(addr_q) < eff_cnt_q)
	`PCQ_ASSERT_IMPL(a_snap_done_state, snap_done, state_q == ST_SNAP)
	`PCQ_ASSERT_NEXT(a_drain_to_done, valid_s2 && last_s2, state_q == ST_DONE)

endmodule

/* rtl/core/pcq_snap.sv */
`timescale 1ns / 1ps

// Uniform grid snap: step = 255 / (levels - 1) by restoring division, then
// (v + step/2) rounded down to a multiple of step as x - (x mod step), clamped to 255, per lane.
module pcq_snap
	import pcq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  rgb_t       pixel,
	input  logic [8:0] level_count,
	output logic       done,
	output rgb_t       result
);

	typedef enum logic [2:0] {
		SN_IDLE = 3'b001,
		SN_STEP = 3'b010,
		SN_REM  = 3'b100
	} sn_state_t;

	localparam logic [3:0] STEP_LAST = 4'd7;
	localparam logic [3:0] REM_LAST  = 4'd8;

	sn_state_t       state_q;
	logic [3:0]      cnt_q;
	logic            done_q;
	logic [7:0]      div_q;
	logic [7:0]      prem_q;
	logic [7:0]      step_q;
	logic [2:0][7:0] px_q;
	logic [2:0][8:0] x_q;
	logic [2:0][8:0] xo_q;
	logic [2:0][7:0] rem_q;
	logic [2:0][7:0] res_q;

	logic [7:0]      div_start;
	logic [8:0]      pt;
	logic            pge;
	logic [7:0]      prem_next;
	logic [7:0]      step_next;
	logic [2:0][8:0] rt;
	logic [2:0][7:0] rem_next;
	logic [2:0][8:0] diff;
	logic [2:0][7:0] snapped;

	always_comb begin
		if (level_count < 9'd2) begin
			div_start = 8'd1;
		end else if (level_count > 9'd256) begin
			div_start = 8'd255;
		end else begin
			div_start = 8'(level_count - 9'd1);
		end
	end

	// Dividend is 255: every bit brought down is a one.
	assign pt        = {prem_q, 1'b1};
	assign pge       = pt >= {1'b0, div_q};
	assign prem_next = pge ? 8'(pt - {1'b0, div_q}) : pt[7:0];
	assign step_next = {step_q[6:0], pge};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt[i]       = {rem_q[i], x_q[i][8]};
			rem_next[i] = (rt[i] >= {1'b0, step_q}) ? 8'(rt[i] - {1'b0, step_q}) : rt[i][7:0];
			diff[i]     = xo_q[i] - {1'b0, rem_next[i]};
			snapped[i]  = diff[i][8] ? 8'd255 : diff[i][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SN_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SN_IDLE: begin
					if (start) begin
						state_q <= SN_STEP;
						cnt_q   <= '0;
					end
				end
				SN_STEP: begin
					if (cnt_q == STEP_LAST) begin
						state_q <= SN_REM;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				SN_REM: begin
					if (cnt_q == REM_LAST) begin
						state_q <= SN_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: state_q <= SN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SN_IDLE: begin
				if (start) begin
					div_q  <= div_start;
					prem_q <= '0;
					step_q <= '0;
					px_q   <= {pixel.r, pixel.g, pixel.b};
				end
			end
			SN_STEP: begin
				prem_q <= prem_next;
				step_q <= step_next;
				if (cnt_q == STEP_LAST) begin
					for (int i = 0; i < 3; i++) begin
						x_q[i]   <= {1'b0, px_q[i]} + {2'b00, step_next[7:1]};
						xo_q[i]  <= {1'b0, px_q[i]} + {2'b00, step_next[7:1]};
						rem_q[i] <= '0;
					end
				end
			end
			SN_REM: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= rem_next[i];
					x_q[i]   <= {x_q[i][7:0], 1'b0};
				end
				if (cnt_q == REM_LAST) begin
					res_q <= snapped;
				end
			end
			default: ;
		endcase
	end

	assign done     = done_q;
	assign result.r = res_q[2];
	assign result.g = res_q[1];
	assign result.b = res_q[0];

endmodule
